// ===== sv/mexp_pkg.sv =====
// Shared types for the modular exponentiation block.
package mexp_pkg;

  // Status of the serial modular multiplier as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

// ===== sv/mexp_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_modmul #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [WORD_BITS-2:0]     start_addend,
  input  logic [WORD_BITS-1:0]     start_mult,
  input  logic [WORD_BITS-2:0]     modulus,
  output logic [WORD_BITS-2:0]     result,
  output mexp_pkg::mm_status_t     status
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-2:0] acc_r, acc_nxt;
  logic [WORD_BITS-2:0] addend_r;
  logic [WORD_BITS-1:0] mult_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;

  logic [WORD_BITS+1:0] sum_c, sub1_c, sub2_c, m_ext;

  // One step: acc <- (2*acc + bit*addend) mod m; the sum stays below 3*m.
  always_comb begin
    m_ext  = {3'b000, modulus};
    sum_c  = {2'b00, acc_r, 1'b0} + (mult_r[WORD_BITS-1] ? {3'b000, addend_r} : '0);
    sub1_c = sum_c - m_ext;
    sub2_c = sum_c - {m_ext[WORD_BITS:0], 1'b0};
    if (!sub2_c[WORD_BITS+1]) begin
      acc_nxt = sub2_c[WORD_BITS-2:0];
    end else if (!sub1_c[WORD_BITS+1]) begin
      acc_nxt = sub1_c[WORD_BITS-2:0];
    end else begin
      acc_nxt = sum_c[WORD_BITS-2:0];
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      addend_r <= start_addend;
      mult_r   <= start_mult;
      cnt_r    <= CW'(WORD_BITS);
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      mult_r <= {mult_r[WORD_BITS-2:0], 1'b0};
      cnt_r  <= cnt_r - CW'(1);
    end
  end

  assign result      = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

`ifndef ASSERT_OFF
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < modulus))
    else $error("modmul result not below modulus");
  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != CW'(1)) |=> busy_r)
    else $error("modmul stopped early");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("modmul flagged done while still busy");
`endif

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer and result register.
//
// Computes base^exponent mod modulus by square-and-multiply, scanning all
// exponent bits from the most significant one down. Every modular product
// runs on one shared bit-serial multiplier. An item with a nonzero exponent
// and modulus takes one pass to reduce the base, one squaring per exponent
// bit and one multiply per set bit. An exponent of zero (result 1) or a
// modulus of zero (result 0) goes straight to the result without the
// multiplier. One item is worked on at a time; the result register lets the
// next item be taken while a result waits for its transfer.
module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_base,
  input  logic        [WORD_BITS-2:0] in_exponent,
  input  logic        [WORD_BITS-2:0] in_modulus,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic        [WORD_BITS-2:0] out_power_mod
);

  localparam int ECW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-2:0] ONE = {{(WORD_BITS-2){1'b0}}, 1'b1};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RED  = 5'b00010,
    ST_SQ   = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-2:0] m_r, m_nxt;
  logic [WORD_BITS-2:0] e_r, e_nxt;
  logic [ECW-1:0]       ecnt_r, ecnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [WORD_BITS-2:0] b_r, b_nxt;
  logic [WORD_BITS-2:0] acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-2:0] out_pm_r, out_pm_nxt;

  logic                 launch;
  logic [WORD_BITS-2:0] launch_a;
  logic [WORD_BITS-1:0] launch_x;
  logic [WORD_BITS-2:0] mm_result;
  mexp_pkg::mm_status_t mm_stat;

  logic [WORD_BITS-1:0] base_u, mag_c;
  logic [WORD_BITS-2:0] bfix_c, init_c;
  logic                 adv;

  // Magnitude of the signed base, the sign-corrected reduced base, and the start value of the accumulator.
  always_comb begin
    base_u = in_base;
    mag_c  = base_u[WORD_BITS-1] ? (~base_u + {{(WORD_BITS-1){1'b0}}, 1'b1}) : base_u;
    bfix_c = (neg_r && mm_result != '0) ? (m_r - mm_result) : mm_result;
    init_c = (m_r == ONE) ? '0 : ONE;
  end

  assign in_stall = (state_r != ST_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    ecnt_nxt      = ecnt_r;
    neg_nxt       = neg_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_pm_nxt    = out_pm_r;
    launch        = 1'b0;
    launch_a      = '0;
    launch_x      = '0;
    adv           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt    = in_modulus;
          e_nxt    = in_exponent;
          ecnt_nxt = ECW'(WORD_BITS - 1);
          neg_nxt  = base_u[WORD_BITS-1];
          if (in_exponent == '0) begin
            acc_nxt   = ONE;
            state_nxt = ST_DONE;
          end else if (in_modulus == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // Base reduction: shift the magnitude in, one bit per cycle.
            launch    = 1'b1;
            launch_a  = ONE;
            launch_x  = mag_c;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_stat.done) begin
          b_nxt     = bfix_c;
          acc_nxt   = init_c;
          launch    = 1'b1;
          launch_a  = init_c;
          launch_x  = {1'b0, init_c};
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mm_stat.done) begin
          acc_nxt = mm_result;
          if (e_r[WORD_BITS-2]) begin
            launch    = 1'b1;
            launch_a  = b_r;
            launch_x  = {1'b0, mm_result};
            state_nxt = ST_MUL;
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          acc_nxt = mm_result;
          adv     = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pm_nxt    = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Move to the next exponent bit, or finish after the last one.
    if (adv) begin
      e_nxt    = {e_r[WORD_BITS-3:0], 1'b0};
      ecnt_nxt = ecnt_r - ECW'(1);
      if (ecnt_r == ECW'(1)) begin
        state_nxt = ST_DONE;
      end else begin
        launch    = 1'b1;
        launch_a  = mm_result;
        launch_x  = {1'b0, mm_result};
        state_nxt = ST_SQ;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    e_r      <= e_nxt;
    ecnt_r   <= ecnt_nxt;
    neg_r    <= neg_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    out_pm_r <= out_pm_nxt;
  end

  mexp_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (launch),
    .start_addend(launch_a),
    .start_mult  (launch_x),
    .modulus     (m_r),
    .result      (mm_result),
    .status      (mm_stat)
  );

  assign out_valid     = out_valid_r;
  assign out_power_mod = out_pm_r;

`ifndef ASSERT_OFF
  a_launch_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> !mm_stat.busy)
    else $error("multiplier launched while busy");
  a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == ST_RED || state_r == ST_SQ || state_r == ST_MUL))
    else $error("multiplier finished outside a working state");
  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ || state_r == ST_MUL) |-> (ecnt_r != '0))
    else $error("exponent bit count ran out");
`endif

endmodule

// ===== verif/mexp_checker.sv =====
// Checker for the modular exponentiation block: predicts each result and compares it.
module mexp_checker #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_base,
  input  logic        [WORD_BITS-2:0] in_exponent,
  input  logic        [WORD_BITS-2:0] in_modulus,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic        [WORD_BITS-2:0] out_power_mod,
  output int unsigned                 error_count,
  output int unsigned                 pending_count,
  output int unsigned                 checked_count
);

  localparam int MAX_REPORTS = 10;

  // Expected powers, oldest first, one per accepted input transfer.
  logic [WORD_BITS-2:0] expected_powers[$];
  int unsigned          mismatches = 0;
  int unsigned          results_seen = 0;

  // Right-to-left binary exponentiation on wide vectors, so no product can overflow.
  function automatic logic [WORD_BITS-2:0] power_mod_of(
    input logic signed [WORD_BITS-1:0] base,
    input logic        [WORD_BITS-2:0] exponent,
    input logic        [WORD_BITS-2:0] modulus
  );
    logic [127:0] m;
    logic [127:0] raw;
    logic [127:0] rem;
    logic [127:0] square;
    logic [127:0] result;
    if (exponent == '0) begin
      return {{(WORD_BITS-2){1'b0}}, 1'b1};
    end
    if (modulus == '0) begin
      return '0;
    end
    m   = 128'(modulus);
    raw = {{(128-WORD_BITS){1'b0}}, base};
    // A negative base maps to its true remainder in 0 .. modulus-1.
    if (base[WORD_BITS-1]) begin
      rem    = ((128'd1 << WORD_BITS) - raw) % m;
      square = (rem == 0) ? 128'd0 : m - rem;
    end else begin
      square = raw % m;
    end
    result = 128'd1 % m;
    for (int i = 0; i < WORD_BITS - 1; i++) begin
      if (exponent[i]) begin
        result = (result * square) % m;
      end
      square = (square * square) % m;
    end
    return result[WORD_BITS-2:0];
  endfunction

  // Track input transfers and check every result transfer against the oldest prediction.
  always @(posedge clk) begin : watch_transfers
    logic [WORD_BITS-2:0] want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_powers.push_back(power_mod_of(in_base, in_exponent, in_modulus));
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_powers.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result %0d: unexpected power_mod %0d with nothing outstanding",
                     results_seen, out_power_mod);
          end
          mismatches++;
        end else begin
          want = expected_powers.pop_front();
          if (out_power_mod !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("result %0d: power_mod expected %0d, got %0d",
                       results_seen, want, out_power_mod);
            end
            mismatches++;
          end
        end
      end
      error_count   <= mismatches;
      pending_count <= expected_powers.size();
      checked_count <= results_seen;
    end
  end

endmodule

// ===== verif/tb_modular_exponentiation.sv =====
// Testbench top for the modular exponentiation block: clock, reset, stimulus and verdict.
module tb_modular_exponentiation;

  localparam int          WORD_BITS     = 32;
  localparam int          RANDOM_ITEMS  = 290;
  localparam int          LONG_GAP_MAX  = 60;
  localparam int          DRAIN_CYCLES  = 2200;
  // Sized for the slowest item plus a long input gap and a long output stall.
  localparam int unsigned CYCLE_LIMIT   = 4 * (RANDOM_ITEMS + 25) * (2081 + 2 * LONG_GAP_MAX);

  localparam logic signed [WORD_BITS-1:0] BASE_MIN = 32'h8000_0000;
  localparam logic signed [WORD_BITS-1:0] BASE_MAX = 32'h7FFF_FFFF;
  localparam logic        [WORD_BITS-2:0] FIELD_MAX = 31'h7FFF_FFFF;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [WORD_BITS-1:0] in_base = '0;
  logic        [WORD_BITS-2:0] in_exponent = '0;
  logic        [WORD_BITS-2:0] in_modulus = 31'd1;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic        [WORD_BITS-2:0] out_power_mod;

  logic        quiet = 1'b0;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned directed_sent = 0;
  int unsigned random_sent = 0;
  int unsigned zero_exp_sent = 0;

  modular_exponentiation #(.WORD_BITS(WORD_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_power_mod(out_power_mod)
  );

  mexp_checker #(.WORD_BITS(WORD_BITS)) power_mod_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_power_mod(out_power_mod),
    .error_count  (error_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_modular_exponentiation: errors");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, LONG_GAP_MAX);
  endfunction

  // Result-side back-pressure: random stalls of random length.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = pick_gap();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item, hold it until its transfer, then idle for a random gap.
  task automatic transfer_item(
    input logic signed [WORD_BITS-1:0] base,
    input logic        [WORD_BITS-2:0] exponent,
    input logic        [WORD_BITS-2:0] modulus
  );
    int unsigned gap;
    in_base     <= base;
    in_exponent <= exponent;
    in_modulus  <= modulus;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (exponent == '0) begin
      zero_exp_sent++;
    end
    gap = pick_gap();
    if (gap != 0) begin
      // Idle payload carries noise; the block must ignore it.
      in_valid    <= 1'b0;
      in_base     <= $urandom();
      in_exponent <= (WORD_BITS-1)'($urandom());
      in_modulus  <= (WORD_BITS-1)'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic signed [WORD_BITS-1:0] base;
    logic        [WORD_BITS-2:0] exponent;
    logic        [WORD_BITS-2:0] modulus;
    int unsigned                 pick;
    int unsigned                 width;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: exponent zero, modulus one, negative bases and field extremes.
    transfer_item(32'sd0, 31'd0, 31'd1);
    transfer_item(32'sd5, 31'd0, FIELD_MAX);
    transfer_item(BASE_MIN, 31'd0, 31'd7);
    transfer_item(32'sd7, 31'd3, 31'd1);
    transfer_item(-32'sd1, FIELD_MAX, 31'd1);
    transfer_item(32'sd2, 31'd10, 31'd1000);
    transfer_item(-32'sd2, 31'd3, 31'd7);
    transfer_item(BASE_MIN, 31'd1, FIELD_MAX);
    transfer_item(BASE_MAX, 31'd1, FIELD_MAX);
    transfer_item(BASE_MAX, FIELD_MAX, FIELD_MAX - 31'd1);
    transfer_item(BASE_MIN, FIELD_MAX, FIELD_MAX);
    transfer_item(32'sd0, 31'd5, 31'd13);
    transfer_item(-32'sd1, 31'd2, 31'd13);
    transfer_item(-32'sd1, 31'd3, 31'd13);
    transfer_item(-32'sd13, 31'd4, 31'd13);
    transfer_item(32'sd3, FIELD_MAX, FIELD_MAX);
    transfer_item(32'sd123456789, 31'h4000_0000, 31'h4000_0003);
    transfer_item(-32'sd7, 31'd1, 31'd2);
    transfer_item(BASE_MAX, FIELD_MAX, 31'h4000_0000);
    transfer_item(32'sd1, FIELD_MAX, 31'd2);
    transfer_item(BASE_MIN, 31'd2, 31'd3);
    directed_sent = 21;

    // Random part: mixed classes of base, exponent and modulus.
    for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx % 90 == 45) begin
        quiet <= 1'b1;
      end else if (idx % 90 == 60) begin
        quiet <= 1'b0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        exponent = '0;
      end else if (pick < 20) begin
        exponent = (WORD_BITS-1)'($urandom_range(1, 15));
      end else if (pick < 45) begin
        width    = $urandom_range(1, WORD_BITS - 2);
        exponent = (WORD_BITS-1)'($urandom()) & ((31'd1 << width) - 31'd1);
      end else if (pick < 50) begin
        exponent = FIELD_MAX;
      end else begin
        exponent = (WORD_BITS-1)'($urandom());
      end

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        modulus = (WORD_BITS-1)'($urandom_range(1, 4));
      end else if (pick < 25) begin
        modulus = (WORD_BITS-1)'($urandom_range(1, 255));
      end else if (pick < 35) begin
        modulus = FIELD_MAX - (WORD_BITS-1)'($urandom_range(0, 15));
      end else if (pick < 42) begin
        modulus = 31'd1 << $urandom_range(0, WORD_BITS - 2);
      end else begin
        modulus = (WORD_BITS-1)'($urandom());
      end
      if (modulus == '0) begin
        modulus = 31'd1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        base = 32'sd0 - 32'($urandom_range(1, 100));
      end else if (pick < 40) begin
        base = 32'($urandom_range(0, 100));
      end else if (pick < 48) begin
        case ($urandom_range(0, 3))
          0: base = BASE_MIN;
          1: base = BASE_MAX;
          2: base = -32'sd1;
          default: base = 32'sd0;
        endcase
      end else begin
        base = $urandom();
      end

      transfer_item(base, exponent, modulus);
      random_sent++;
    end

    // Drain: wait for every outstanding result, then watch for strays.
    in_valid <= 1'b0;
    quiet    <= 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random items, %0d with exponent zero.",
             directed_sent, random_sent, zero_exp_sent);
    $display("Checked %0d results in %0d cycles, %0d mismatches, %0d still outstanding.",
             checked_count, cycle_count, error_count, pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_modular_exponentiation: clean");
    end else begin
      $display("tb_modular_exponentiation: errors");
    end
    $finish;
  end

endmodule
